// ===== sv/ghp_pkg.sv =====
// Shared types and constants of the generational handle pool.
// No dependencies; imported by every module of the block.
package ghp_pkg;

  localparam int SLOTS     = 64;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int GEN_W     = 32;
  localparam int PAYLOAD_W = 32;

  // request codes
  localparam logic [2:0] REQ_INSERT   = 3'd0;
  localparam logic [2:0] REQ_REMOVE   = 3'd1;
  localparam logic [2:0] REQ_GET      = 3'd2;
  localparam logic [2:0] REQ_CONTAINS = 3'd3;
  localparam logic [2:0] REQ_CLEAR    = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_STALE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EXEC
  } ghp_state_e;

  // write request into the slot store
  typedef struct packed {
    logic                 gen_we;
    logic                 pay_we;
    logic [SLOT_W-1:0]    addr;
    logic [GEN_W-1:0]     gen;
    logic [PAYLOAD_W-1:0] payload;
  } slot_wr_t;

  // write request into the free stack
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [SLOT_W-1:0] data;
  } fs_wr_t;

endpackage

// ===== sv/ghp_slot_mem.sv =====
// Slot store: generation and payload memories plus per-slot valid bits.
// Depends on ghp_pkg. Registered read; invalid slots read as zero.
module ghp_slot_mem (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  ghp_pkg::slot_wr_t        wr_i,
  input  logic                     re_i,
  input  logic [ghp_pkg::SLOT_W-1:0]    raddr_i,
  output logic [ghp_pkg::GEN_W-1:0]     gen_o,
  output logic [ghp_pkg::PAYLOAD_W-1:0] payload_o
);
  import ghp_pkg::*;

  logic [GEN_W-1:0]     gen_mem [SLOTS];
  logic [PAYLOAD_W-1:0] pay_mem [SLOTS];
  logic [SLOTS-1:0]     vld_q;
  logic [GEN_W-1:0]     gen_rd_q;
  logic [PAYLOAD_W-1:0] pay_rd_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.gen_we) begin
      gen_mem[wr_i.addr] <= wr_i.gen;
    end
    if (wr_i.pay_we) begin
      pay_mem[wr_i.addr] <= wr_i.payload;
    end
    if (re_i) begin
      gen_rd_q <= gen_mem[raddr_i];
      pay_rd_q <= pay_mem[raddr_i];
    end
  end

  // valid bits stand in for the zero reset of both memories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_i.gen_we || wr_i.pay_we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign gen_o     = rd_vld_q ? gen_rd_q : '0;
  assign payload_o = rd_vld_q ? pay_rd_q : '0;

endmodule

// ===== sv/ghp_free_stack.sv =====
// Free stack storage: slot numbers of removed slots.
// Depends on ghp_pkg. One write and one registered read per cycle.
module ghp_free_stack (
  input  logic                       clk_i,
  input  ghp_pkg::fs_wr_t            wr_i,
  input  logic                       re_i,
  input  logic [ghp_pkg::SLOT_W-1:0] raddr_i,
  output logic [ghp_pkg::SLOT_W-1:0] rdata_o
);
  import ghp_pkg::*;

  logic [SLOT_W-1:0] stack_mem [SLOTS];
  logic [SLOT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      stack_mem[wr_i.addr] <= wr_i.data;
    end
    if (re_i) begin
      rdata_q <= stack_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/generational_handle_pool_unit.sv =====
// Generational handle pool, top level.
// Depends on ghp_pkg, ghp_slot_mem and ghp_free_stack.
//
// Usage:
//   Request channel (in_valid_i / in_ready_o) carries one item per request:
//   insert, remove, get, contains or clear. Response channel (out_valid_o /
//   out_ready_i) returns exactly one item per request, in order.
//   A handle is a slot number plus a generation; a slot is live while its
//   generation is odd. Insert pops the free stack first, else takes the
//   next never-used slot, else answers full.
// Timing:
//   An item goes from acceptance through the execute step to the response
//   register; an insert that pops the free stack passes a pop step first:
//   the free-stack read and the slot read are each a synchronous memory
//   access, and the slot read depends on the popped slot number. One item
//   is in flight at a time; the next is accepted once its response is registered.
// Reset and stall:
//   Reset empties the pool at once (valid bits clear, counters zero). Clear
//   does the same. A held response does not block acceptance of the next
//   item; that item waits in its execute step until the response register
//   frees up.
module generational_handle_pool_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    req_type_i,
  input  logic [7:0]                    slot_number_i,
  input  logic [31:0]                   handle_generation_i,
  input  logic                          payload_given_i,
  input  logic [31:0]                   payload_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [ghp_pkg::SLOT_W-1:0]    new_slot_o,
  output logic [31:0]                   new_generation_o,
  output logic [31:0]                   read_payload_o,
  output logic [ghp_pkg::CNT_W-1:0]     live_count_o
);
  import ghp_pkg::*;

  ghp_state_e state_q, state_d;

  // latched request
  logic [2:0]           req_q;
  logic [7:0]           slot_q;
  logic [GEN_W-1:0]     hgen_q;
  logic                 given_q;
  logic [PAYLOAD_W-1:0] data_q;
  logic [SLOT_W-1:0]    id_q, id_d;
  logic                 pop_q, full_q;

  // pool counters
  logic [CNT_W-1:0] fd_q, fd_d;     // free stack depth
  logic [CNT_W-1:0] nf_q, nf_d;     // next never-used slot
  logic [CNT_W-1:0] live_q, live_d;

  // response register
  logic                 out_valid_q;
  logic [1:0]           status_q, status_d;
  logic [SLOT_W-1:0]    nslot_q, nslot_d;
  logic [GEN_W-1:0]     ngen_q, ngen_d;
  logic [PAYLOAD_W-1:0] rpay_q, rpay_d;

  logic              accept, fire, stack_path, pool_full;
  logic [CNT_W-1:0]  fd_m1;
  logic              fs_re, slot_re, clr;
  logic [SLOT_W-1:0] fs_rdata, slot_raddr;
  fs_wr_t            fs_wr;
  slot_wr_t          slot_wr;
  logic [GEN_W-1:0]     gen_rd, gen_inc;
  logic [PAYLOAD_W-1:0] pay_rd;
  logic              in_range, hit;

  assign accept     = in_valid_i && in_ready_o;
  assign fire       = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign stack_path = (req_type_i == REQ_INSERT) && (fd_q != '0);
  assign pool_full  = (fd_q == '0) && (nf_q == CNT_W'(SLOTS));
  assign fd_m1      = fd_q - 1'b1;
  assign in_ready_o = (state_q == S_IDLE);

  ghp_free_stack u_free_stack (
    .clk_i   (clk_i),
    .wr_i    (fs_wr),
    .re_i    (fs_re),
    .raddr_i (fd_m1[SLOT_W-1:0]),
    .rdata_o (fs_rdata)
  );

  ghp_slot_mem u_slot_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr),
    .wr_i      (slot_wr),
    .re_i      (slot_re),
    .raddr_i   (slot_raddr),
    .gen_o     (gen_rd),
    .payload_o (pay_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = stack_path ? S_POP : S_EXEC;
        end
      end
      S_POP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory read control
  always_comb begin
    fs_re      = 1'b0;
    slot_re    = 1'b0;
    id_d       = id_q;
    slot_raddr = id_q;
    case (state_q)
      S_IDLE: begin
        fs_re = accept && stack_path;
        id_d  = (req_type_i == REQ_INSERT) ? nf_q[SLOT_W-1:0]
                                           : slot_number_i[SLOT_W-1:0];
        slot_re    = accept && !stack_path;
        slot_raddr = id_d;
      end
      S_POP: begin
        id_d       = fs_rdata;
        slot_re    = 1'b1;
        slot_raddr = fs_rdata;
      end
      default: begin
        id_d = id_q;
      end
    endcase
  end

  // execute step: slot data is valid in S_EXEC
  assign gen_inc  = gen_rd + 1'b1;
  assign in_range = ({1'b0, slot_q} < 9'(SLOTS));
  assign hit      = in_range && (gen_rd == hgen_q) && gen_rd[0];

  always_comb begin
    status_d = STAT_OK;
    nslot_d  = '0;
    ngen_d   = '0;
    rpay_d   = '0;
    fd_d     = fd_q;
    nf_d     = nf_q;
    live_d   = live_q;
    clr      = 1'b0;
    fs_wr    = '0;
    slot_wr  = '0;
    slot_wr.addr    = id_q;
    slot_wr.gen     = gen_inc;
    slot_wr.payload = given_q ? data_q : '0;
    fs_wr.addr      = fd_q[SLOT_W-1:0];
    fs_wr.data      = slot_q[SLOT_W-1:0];
    case (req_q)
      REQ_INSERT: begin
        if (full_q) begin
          status_d = STAT_FULL;
        end else begin
          slot_wr.gen_we = fire;
          slot_wr.pay_we = fire;
          live_d  = live_q + 1'b1;
          nslot_d = id_q;
          ngen_d  = gen_inc;
          if (pop_q) begin
            fd_d = fd_m1;
          end else begin
            nf_d = nf_q + 1'b1;
          end
        end
      end
      REQ_REMOVE: begin
        if (hit && (fd_q < CNT_W'(SLOTS))) begin
          slot_wr.gen_we = fire;
          fs_wr.we       = fire;
          fd_d           = fd_q + 1'b1;
          if (live_q != '0) begin
            live_d = live_q - 1'b1;
          end
        end else begin
          status_d = STAT_STALE;
        end
      end
      REQ_GET: begin
        if (hit) begin
          rpay_d = pay_rd;
        end else begin
          status_d = STAT_STALE;
        end
      end
      REQ_CONTAINS: begin
        if (!hit) begin
          status_d = STAT_STALE;
        end
      end
      REQ_CLEAR: begin
        clr    = fire;
        fd_d   = '0;
        nf_d   = '0;
        live_d = '0;
      end
      default: begin
        status_d = STAT_STALE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fd_q        <= '0;
      nf_q        <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        fd_q        <= fd_d;
        nf_q        <= nf_d;
        live_q      <= live_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    if (accept) begin
      req_q   <= req_type_i;
      slot_q  <= slot_number_i;
      hgen_q  <= handle_generation_i;
      given_q <= payload_given_i;
      data_q  <= payload_i[PAYLOAD_W-1:0];
      pop_q   <= stack_path;
      full_q  <= pool_full;
    end
    if (fire) begin
      status_q <= status_d;
      nslot_q  <= nslot_d;
      ngen_q   <= ngen_d;
      rpay_q   <= rpay_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign new_slot_o       = nslot_q;
  assign new_generation_o = ngen_q;
  assign read_payload_o   = 32'(rpay_q);
  assign live_count_o     = live_q;

  // one item in flight: acceptance always leaves the idle state
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // every live or freed slot was once taken fresh
  a_pool_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, live_q} + {1'b0, fd_q}) == {1'b0, nf_q})
    else $error("live count and free depth disagree with fresh pointer");

  // full only when every slot is live
  a_full_means_all_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_FULL)) |-> (live_count_o == CNT_W'(SLOTS)))
    else $error("pool full reported with free slots");

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (live_q <= CNT_W'(SLOTS)))
    else $error("live count beyond pool size");

endmodule
